// ===== src/msw_pkg.sv =====
`default_nettype none

package msw_pkg;

    // Field widths fixed by the interface
    localparam int START_W = 20;
    localparam int DUR_W   = 12;
    localparam int CAT_W   = 2;
    localparam int FIN_W   = 24;
    localparam int SUM_W   = 32;

    // Configuration space: one server-count register per category slot
    localparam int NUM_REGS = 4;
    localparam int SRV_W    = 5;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_UPD
    } state_t;

    // Update command broadcast to every cell of one category row
    typedef struct packed {
        logic             en;
        logic             pop;
        logic [FIN_W-1:0] fin;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/msw_cell.sv =====
`default_nettype none

module msw_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire                       clk,
    input  msw_pkg::cell_ctl_t        ctl,
    input  wire  [CNT_W-1:0]          len,
    input  wire  [msw_pkg::FIN_W-1:0] left_val,
    input  wire                       left_keep,
    input  wire  [msw_pkg::FIN_W-1:0] right_val,
    output logic [msw_pkg::FIN_W-1:0] val,
    output logic                      keep
);
    import msw_pkg::*;

    logic [FIN_W-1:0] val_reg;
    logic [FIN_W-1:0] val_next;
    logic [FIN_W-1:0] cand;
    logic [FIN_W-1:0] left_cand;
    logic [CNT_W-1:0] alen;
    logic             in_range;

    // On a pop the row first slides one place toward the head
    always_comb
    begin
        cand      = ctl.pop ? right_val : val_reg;
        left_cand = ctl.pop ? val_reg : left_val;
        alen      = ctl.pop ? (len - CNT_W'(1)) : len;
        in_range  = CNT_W'(IDX) < alen;
        keep      = in_range && (cand <= ctl.fin);
        if (keep)
        begin
            val_next = cand;
        end
        else if (left_keep)
        begin
            val_next = ctl.fin;
        end
        else
        begin
            val_next = left_cand;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

`default_nettype wire

// ===== src/msw_chain.sv =====
`default_nettype none

module msw_chain #(
    parameter int MAX_SERVERS = 16
) (
    input  wire                              clk,
    input  msw_pkg::cell_ctl_t               ctl,
    input  wire  [$clog2(MAX_SERVERS+1)-1:0] len,
    output logic [msw_pkg::FIN_W-1:0]        head
);
    import msw_pkg::*;

    localparam int CNT_W = $clog2(MAX_SERVERS + 1);

    logic [FIN_W-1:0] vals  [MAX_SERVERS];
    logic             keeps [MAX_SERVERS];

    // Row is kept sorted ascending; cell 0 holds the earliest finish time
    for (genvar j = 0; j < MAX_SERVERS; j++)
    begin : g_cell
        logic [FIN_W-1:0] lv;
        logic             lk;
        logic [FIN_W-1:0] rv;

        if (j == 0)
        begin : g_first
            assign lv = vals[0];
            assign lk = 1'b1;
        end
        else
        begin : g_mid
            assign lv = vals[j-1];
            assign lk = keeps[j-1];
        end

        if (j == MAX_SERVERS - 1)
        begin : g_last
            assign rv = vals[j];
        end
        else
        begin : g_inner
            assign rv = vals[j+1];
        end

        msw_cell #(
            .IDX   (j),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .len       (len),
            .left_val  (lv),
            .left_keep (lk),
            .right_val (rv),
            .val       (vals[j]),
            .keep      (keeps[j])
        );
    end

    assign head = vals[0];

endmodule

`default_nettype wire

// ===== src/multi_server_wait_accumulator_top.sv =====
`default_nettype none

// Channel   | Handshake                      | Beat contents
// ----------+--------------------------------+---------------------------------------------
// request   | in_valid / in_ready            | new_batch, start_time, duration, category
// result    | out_valid / out_ready          | request_wait, total_wait
// config    | APB psel/penable/pwrite/pready | paddr, pwdata, prdata (servers_cat0..3)
//
// Each request runs a calc step, which reads the head cell of the category's sorted
// row and forms wait and finish time, then an update step, which shifts the row
// (pop head and insert, or insert only), updates the count and the total and loads the
// result register. A new request can be accepted during the update step of the one before.
// Reset clears busy counts, total, FSM and output valid; server counts reset to 1.
// Finish-time cells are not cleared: only cells below the busy count are read.
// A stalled result register holds the update cycle; the next request then waits.
module multi_server_wait_accumulator_top #(
    parameter int NUM_CATEGORIES = 4,
    parameter int MAX_SERVERS    = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // request channel
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          new_batch,
    input  wire  [msw_pkg::START_W-1:0]  start_time,
    input  wire  [msw_pkg::DUR_W-1:0]    duration,
    input  wire  [msw_pkg::CAT_W-1:0]    category,
    // result channel
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [msw_pkg::FIN_W-1:0]    request_wait,
    output logic [msw_pkg::SUM_W-1:0]    total_wait,
    // configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [msw_pkg::ADDR_W-1:0]   paddr,
    input  wire  [msw_pkg::DATA_W-1:0]   pwdata,
    output logic [msw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import msw_pkg::*;

    localparam int CNT_W = $clog2(MAX_SERVERS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SRV_W-1:0]      servers_reg [NUM_REGS];
    logic [ADDR_W-3:0]     cfg_idx;
    logic                  cfg_wr;

    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = DATA_W'(servers_reg[cfg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                servers_reg[i] <= SRV_W'(1);
            end
        end
        else if (cfg_wr)
        begin
            servers_reg[cfg_idx] <= pwdata[SRV_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;
    logic   upd_go;
    logic   in_acc;
    logic   calc_load;
    logic   upd_fire;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Update may retire only when the result register is free or draining
    assign upd_go = !out_valid_reg || out_ready;
    assign in_acc = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_go)
                begin
                    state_next = in_valid ? S_CALC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        calc_load = 1'b0;
        upd_fire  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_CALC:
            begin
                calc_load = 1'b1;
            end
            S_UPD:
            begin
                in_ready = upd_go;
                upd_fire = upd_go;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Request capture
    // ------------------------------------------------------------------
    logic               newb_reg;
    logic [START_W-1:0] start_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [CAT_W-1:0]   cat_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            newb_reg  <= new_batch;
            start_reg <= start_time;
            dur_reg   <= duration;
            cat_reg   <= category;
        end
    end

    // ------------------------------------------------------------------
    // Calc cycle: head lookup, wait and finish time
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] busy_count_reg [NUM_CATEGORIES];
    logic [CNT_W-1:0] busy_next      [NUM_CATEGORIES];
    logic [FIN_W-1:0] heads          [NUM_CATEGORIES];

    logic [CNT_W-1:0] busy_cur;
    logic [FIN_W-1:0] head_sel;
    logic             cat_ok;
    logic [31:0]      srv_eff;
    logic             pop;
    logic             late;
    logic [FIN_W-1:0] start_ext;
    logic [FIN_W:0]   fin_from_head;
    logic [FIN_W:0]   fin_from_start;
    logic [FIN_W:0]   fin_raw;
    logic [FIN_W-1:0] fin_calc;
    logic [FIN_W-1:0] wait_calc;

    always_comb
    begin
        busy_cur = '0;
        head_sel = heads[0];
        for (int g = 0; g < NUM_CATEGORIES; g++)
        begin
            if (32'(cat_reg) == g)
            begin
                busy_cur = busy_count_reg[g];
                head_sel = heads[g];
            end
        end
        // a new batch sees every row empty
        if (newb_reg)
        begin
            busy_cur = '0;
        end

        cat_ok = 32'(cat_reg) < NUM_CATEGORIES;

        // register value 0 acts as one server, values above the row depth saturate
        srv_eff = 32'(servers_reg[cat_reg]);
        if (srv_eff == 32'd0)
        begin
            srv_eff = 32'd1;
        end
        if (srv_eff > MAX_SERVERS)
        begin
            srv_eff = MAX_SERVERS;
        end

        pop       = cat_ok && (32'(busy_cur) >= srv_eff);
        start_ext = FIN_W'(start_reg);
        late      = pop && (head_sel > start_ext);
        wait_calc = late ? (head_sel - start_ext) : '0;

        fin_from_head  = {1'b0, head_sel} + (FIN_W+1)'(dur_reg);
        fin_from_start = {1'b0, start_ext} + (FIN_W+1)'(dur_reg);
        fin_raw        = late ? fin_from_head : fin_from_start;
        fin_calc       = fin_raw[FIN_W] ? '1 : fin_raw[FIN_W-1:0];
    end

    logic               upd_ok_reg;
    logic               upd_pop_reg;
    logic               upd_newb_reg;
    logic [CAT_W-1:0]   upd_cat_reg;
    logic [CNT_W-1:0]   upd_len_reg;
    logic [FIN_W-1:0]   upd_fin_reg;
    logic [FIN_W-1:0]   upd_wait_reg;

    always_ff @(posedge clk)
    begin
        if (calc_load)
        begin
            upd_ok_reg   <= cat_ok;
            upd_pop_reg  <= pop;
            upd_newb_reg <= newb_reg;
            upd_cat_reg  <= cat_reg;
            upd_len_reg  <= busy_cur;
            upd_fin_reg  <= fin_calc;
            upd_wait_reg <= wait_calc;
        end
    end

    // ------------------------------------------------------------------
    // Update cycle: one sorted cell row per category
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NUM_CATEGORIES; g++)
    begin : g_row
        cell_ctl_t row_ctl;

        assign row_ctl.en  = upd_fire && upd_ok_reg && (32'(upd_cat_reg) == g);
        assign row_ctl.pop = upd_pop_reg;
        assign row_ctl.fin = upd_fin_reg;

        msw_chain #(
            .MAX_SERVERS (MAX_SERVERS)
        ) u_chain (
            .clk  (clk),
            .ctl  (row_ctl),
            .len  (upd_len_reg),
            .head (heads[g])
        );
    end

    always_comb
    begin
        for (int g = 0; g < NUM_CATEGORIES; g++)
        begin
            busy_next[g] = busy_count_reg[g];
            if (upd_fire)
            begin
                if (upd_newb_reg)
                begin
                    busy_next[g] = '0;
                end
                // a free server was taken: the row grows by one
                if (upd_ok_reg && !upd_pop_reg && (32'(upd_cat_reg) == g))
                begin
                    busy_next[g] = upd_len_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_CATEGORIES; g++)
            begin
                busy_count_reg[g] <= '0;
            end
        end
        else
        begin
            for (int g = 0; g < NUM_CATEGORIES; g++)
            begin
                busy_count_reg[g] <= busy_next[g];
            end
        end
    end

    // Saturating running total
    logic [SUM_W-1:0] wait_sum_reg;
    logic [SUM_W-1:0] wait_sum_next;
    logic [SUM_W-1:0] sum_base;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_new;

    always_comb
    begin
        sum_base      = upd_newb_reg ? '0 : wait_sum_reg;
        sum_wide      = {1'b0, sum_base} + (SUM_W+1)'(upd_wait_reg);
        sum_new       = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        wait_sum_next = upd_fire ? sum_new : wait_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_sum_reg <= '0;
        end
        else
        begin
            wait_sum_reg <= wait_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [FIN_W-1:0] request_wait_reg;
    logic [SUM_W-1:0] total_wait_reg;

    assign out_valid_next = upd_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            request_wait_reg <= upd_wait_reg;
            total_wait_reg   <= sum_new;
        end
    end

    assign out_valid    = out_valid_reg;
    assign request_wait = request_wait_reg;
    assign total_wait   = total_wait_reg;

endmodule

`default_nettype wire

// ===== src/msw_checker.sv =====
`default_nettype none

module msw_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_ready,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire [msw_pkg::FIN_W-1:0]    request_wait,
    input wire [msw_pkg::SUM_W-1:0]    total_wait,
    input wire                         pready
);
    import msw_pkg::*;

    // result beat held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_wait))
        else $error("result beat dropped or changed while stalled");

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted back to back");

    // the total includes this beat's wait
    a_total_covers_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (total_wait >= SUM_W'(request_wait)))
        else $error("total below request wait");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready deasserted");

endmodule

bind multi_server_wait_accumulator_top msw_checker u_msw_checker (.*);

`default_nettype wire

// ===== bench/msw_wait_checker.sv =====
`default_nettype none

// Watches the request, result and register beats; predicts each wait and the running total.
module msw_wait_checker #(
    parameter int NUM_CATEGORIES = 4,
    parameter int MAX_SERVERS    = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    input  wire                          in_ready,
    input  wire                          new_batch,
    input  wire  [msw_pkg::START_W-1:0]  start_time,
    input  wire  [msw_pkg::DUR_W-1:0]    duration,
    input  wire  [msw_pkg::CAT_W-1:0]    category,
    input  wire                          out_valid,
    input  wire                          out_ready,
    input  wire  [msw_pkg::FIN_W-1:0]    request_wait,
    input  wire  [msw_pkg::SUM_W-1:0]    total_wait,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire                          pready,
    input  wire  [msw_pkg::ADDR_W-1:0]   paddr,
    input  wire  [msw_pkg::DATA_W-1:0]   pwdata,
    output int                           fail_count,
    output int                           pending
);
    import msw_pkg::*;

    typedef struct packed {
        logic [FIN_W-1:0] wait_ticks;
        logic [SUM_W-1:0] total;
    } wait_result_t;

    localparam logic [FIN_W-1:0] FIN_SAT = '1;
    localparam logic [SUM_W-1:0] SUM_SAT = '1;

    logic [FIN_W-1:0] finish_at [NUM_CATEGORIES][MAX_SERVERS];
    int unsigned      busy [NUM_CATEGORIES];
    logic [SUM_W-1:0] wait_total;
    logic [SRV_W-1:0] servers [NUM_REGS];
    wait_result_t     waits_due [$];
    wait_result_t     due;

    initial fail_count = 0;

    // print is capped, the count is not
    task automatic report(string msg);
        if (fail_count < 100)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic wait_result_t predict_wait(logic fresh, logic [START_W-1:0] start,
                                                  logic [DUR_W-1:0] dur, logic [CAT_W-1:0] cat);
        int unsigned      srv;
        int unsigned      slot;
        int unsigned      i;
        logic [FIN_W-1:0] begin_at;
        logic [FIN_W:0]   fin;
        logic [SUM_W:0]   acc;
        wait_result_t     r;

        if (fresh)
        begin
            foreach (busy[c])
                busy[c] = 0;
            wait_total = '0;
        end
        r.wait_ticks = '0;
        begin_at     = FIN_W'(start);

        if (cat < NUM_CATEGORIES)
        begin
            srv = servers[cat];
            if (srv == 0)
                srv = 1;
            if (srv > MAX_SERVERS)
                srv = MAX_SERVERS;

            if (busy[cat] >= srv)
            begin
                // all servers taken: the earliest finish frees one (lowest slot on ties)
                slot = 0;
                for (i = 1; i < busy[cat]; i++)
                    if (finish_at[cat][i] < finish_at[cat][slot])
                        slot = i;
                if (finish_at[cat][slot] > begin_at)
                begin
                    r.wait_ticks = finish_at[cat][slot] - begin_at;
                    begin_at     = finish_at[cat][slot];
                end
            end
            else
            begin
                slot = busy[cat];
                busy[cat]++;
            end

            fin = {1'b0, begin_at} + (FIN_W+1)'(dur);
            finish_at[cat][slot] = fin[FIN_W] ? FIN_SAT : fin[FIN_W-1:0];

            acc = {1'b0, wait_total} + (SUM_W+1)'(r.wait_ticks);
            wait_total = acc[SUM_W] ? SUM_SAT : acc[SUM_W-1:0];
        end
        r.total = wait_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (busy[c])
                busy[c] = 0;
            foreach (servers[k])
                servers[k] = 1;
            wait_total = '0;
            waits_due.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                servers[paddr[ADDR_W-1:2]] = pwdata[SRV_W-1:0];

            // result first: a result beat never belongs to a request taken at the same edge
            if (out_valid && out_ready)
            begin
                if (waits_due.size() == 0)
                    report($sformatf("result beat wait=%0d total=%0d with nothing outstanding",
                                     request_wait, total_wait));
                else
                begin
                    due = waits_due.pop_front();
                    if (request_wait !== due.wait_ticks)
                        report($sformatf("request_wait exp %0d got %0d",
                                         due.wait_ticks, request_wait));
                    if (total_wait !== due.total)
                        report($sformatf("total_wait exp %0d got %0d", due.total, total_wait));
                end
            end

            if (in_valid && in_ready)
                waits_due.push_back(predict_wait(new_batch, start_time, duration, category));

            pending <= waits_due.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/multi_server_wait_accumulator_top_test.sv =====
`default_nettype none

// Drives request beats and register writes, stalls the result side, and gives the verdict.
// All prediction and comparison sits in msw_wait_checker.
module multi_server_wait_accumulator_top_test;
    import msw_pkg::*;

    localparam int NUM_CATEGORIES = 4;
    localparam int MAX_SERVERS    = 16;

    // register indexes; byte address is 4 * index
    localparam int SERVERS_CAT0 = 0;
    localparam int SERVERS_CAT1 = 1;
    localparam int SERVERS_CAT2 = 2;
    localparam int SERVERS_CAT3 = 3;

    localparam int MAX_GAP        = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int START_MAX      = (1 << START_W) - 1;
    localparam int DUR_MAX        = (1 << DUR_W) - 1;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                new_batch  = 1'b0;
    logic [START_W-1:0]  start_time = '0;
    logic [DUR_W-1:0]    duration   = '0;
    logic [CAT_W-1:0]    category   = '0;
    logic                out_ready  = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [DATA_W-1:0]   pwdata     = '0;

    logic                in_ready;
    logic                out_valid;
    logic [FIN_W-1:0]    request_wait;
    logic [SUM_W-1:0]    total_wait;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  quiet_cycles = 0;

    // when set, neither side inserts idle cycles
    bit                  steady = 1'b0;

    multi_server_wait_accumulator_top #(
        .NUM_CATEGORIES (NUM_CATEGORIES),
        .MAX_SERVERS    (MAX_SERVERS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .new_batch    (new_batch),
        .start_time   (start_time),
        .duration     (duration),
        .category     (category),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .request_wait (request_wait),
        .total_wait   (total_wait),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    msw_wait_checker #(
        .NUM_CATEGORIES (NUM_CATEGORIES),
        .MAX_SERVERS    (MAX_SERVERS)
    ) u_wait_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .new_batch    (new_batch),
        .start_time   (start_time),
        .duration     (duration),
        .category     (category),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .request_wait (request_wait),
        .total_wait   (total_wait),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Idle cycles before a beat: at least a quarter of the draws are zero so that
    // back-to-back runs show up even in the busy phases.
    function automatic int draw_gap();
        if (steady)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Register values lean on the edges: 0 acts as one server, 17 and 31 clamp to sixteen.
    function automatic int pick_servers();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return MAX_SERVERS;
            3:       return MAX_SERVERS + 1;
            4:       return 31;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    // One request beat. Valid stays high across back-to-back beats (no low/high in one step);
    // after a gap it goes low first. Returns in the time step of the accepting edge.
    task automatic send_request(logic nb, int st, int dur, int cat);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        new_batch  <= nb;
        start_time <= START_W'(st);
        duration   <= DUR_W'(dur);
        category   <= CAT_W'(cat);
        do @(posedge clk); while (!in_ready);
    endtask

    // Setup phase, access phase, then an idle bus so the next write starts clean.
    task automatic write_servers(int idx, int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off the sender until every outstanding result has been taken, then let
    // the update cycle finish before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result side: random stall before each beat, none while steady.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, pending);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int   t;
        int   st;
        int   dur;
        int   cat;
        logic nb;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // cat0 two servers, cat1 one, cat2 zero (acts as one), cat3 31 (clamps to sixteen)
        write_servers(SERVERS_CAT0, 2);
        write_servers(SERVERS_CAT1, 1);
        write_servers(SERVERS_CAT2, 0);
        write_servers(SERVERS_CAT3, 31);

        send_request(1'b1, 0, 0, 0);              // zero-length service, finish = start
        send_request(1'b0, 0, DUR_MAX, 0);        // second server of cat0
        send_request(1'b0, 0, 1, 0);              // both busy; earliest finish not later: no wait
        send_request(1'b0, 0, 10, 0);             // earliest now 1: waits one tick
        send_request(1'b0, 5, 100, 1);            // single server
        send_request(1'b0, 5, 1, 1);              // waits behind the first
        send_request(1'b0, START_MAX, DUR_MAX, 1);// latest start, longest service
        send_request(1'b0, 100, 50, 2);
        send_request(1'b0, 90, 7, 2);             // start earlier than the stored finish
        repeat (5)
            send_request(1'b0, 200, 30, 3);       // many servers, equal finish times
        send_request(1'b0, 200, DUR_MAX, 3);
        send_request(1'b1, START_MAX, DUR_MAX, 3);// new batch empties every category
        send_request(1'b0, START_MAX, DUR_MAX, 3);

        // server count dropped under the busy count mid-batch: earliest entry is replaced
        settle();
        write_servers(SERVERS_CAT3, 1);
        repeat (3)
            send_request(1'b0, START_MAX, 12, 3);

        // ---- long-wait run ----
        // One server: a late first request pushes the finish time past a million ticks,
        // then starts pinned at 0 with the longest service make every wait large and
        // growing by the duration. No idling so the run stays short.
        settle();
        write_servers(SERVERS_CAT0, 1);
        steady = 1'b1;
        send_request(1'b1, START_MAX, DUR_MAX, 0);
        repeat (36)
            send_request(1'b0, 0, DUR_MAX, 0);
        repeat (3)
            send_request(1'b0, START_MAX, DUR_MAX, 0);
        steady = 1'b0;

        // ---- random phases ----
        // Mostly well-formed batches: nondecreasing starts with small steps so requests
        // queue up. Odd phases carry the batch over a register change. About one beat
        // in ten is noise: any start, any duration, sometimes a stray new_batch.
        t = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            write_servers(SERVERS_CAT0, pick_servers());
            write_servers(SERVERS_CAT1, pick_servers());
            write_servers(SERVERS_CAT2, pick_servers());
            write_servers(SERVERS_CAT3, pick_servers());
            steady = (phase == 2);

            for (int n = 0; n < 90; n++)
            begin
                nb = 1'b0;
                if ((n == 0 && phase % 2 == 0) || $urandom_range(0, 49) == 0)
                begin
                    nb = 1'b1;
                    t  = $urandom_range(0, 1) ? $urandom_range(0, START_MAX)
                                              : $urandom_range(0, 1000);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    nb  = nb | ($urandom_range(0, 7) == 0);
                    st  = $urandom_range(0, START_MAX);
                    dur = $urandom_range(0, DUR_MAX);
                end
                else
                begin
                    t = t + $urandom_range(0, 80);
                    if (t > START_MAX)
                        t = START_MAX;
                    st  = t;
                    dur = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DUR_MAX)
                                                      : $urandom_range(1, 300);
                end
                cat = $urandom_range(0, NUM_CATEGORIES - 1);
                send_request(nb, st, dur, cat);
            end
        end
        steady = 1'b0;

        // ---- drain and verdict ----
        settle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/msw_pkg.sv
src/msw_cell.sv
src/msw_chain.sv
src/multi_server_wait_accumulator_top.sv
src/msw_checker.sv
bench/msw_wait_checker.sv
bench/multi_server_wait_accumulator_top_test.sv
